@@ design/vlaf_pkg.sv @@
// ----------------------------------------------------------------------------
// vlaf_pkg
// shared constants, register indexes and the arctangent table for the
// velocity and look-angle feature pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package vlaf_pkg;

  // number of cordic micro-rotations in each of the two cordic sections
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;

  // 1 / cordic gain, Q0.30
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  // atan(2^-i) as 32-bit binary angles
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MOVING_THRESHOLD = 2'd0,
    REG_SPEED_RECIPROCAL = 2'd1,
    REG_PITCH_RECIPROCAL = 2'd2
  } reg_index_t;

  localparam logic [15:0] MOVING_THRESHOLD_RESET = 16'd1;
  localparam logic [23:0] SPEED_RECIPROCAL_RESET = 24'd52429;
  localparam logic [23:0] PITCH_RECIPROCAL_RESET = 24'd186414;

endpackage

`default_nettype wire

@@ design/velocity_look_angle_features_top.sv @@
// ----------------------------------------------------------------------------
// velocity_look_angle_features_top
// horizontal speed, heading-relative look sine/cosine and scaled speed and
// pitch ratios, computed by a fully pipelined pair of cordic sections
// ----------------------------------------------------------------------------
// path: entry stage, vectoring section, gain stage, setup stage, rotation section, output stage
// throughput: one request per cycle while results are taken; every stage holds one
//   request, so the rate is set by the single-step stages of the two cordic sections
// a stalled result freezes the whole pipeline until it is taken
// reset (rst, synchronous): empties the pipeline and reloads the three
//   configuration registers with their default values
`default_nettype none

module velocity_look_angle_features_top (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] vel_x,
  input  wire logic signed [15:0] vel_y,
  input  wire logic signed [15:0] vel_z,
  input  wire logic [15:0]        yaw_angle,
  input  wire logic signed [15:0] pitch_angle,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             speed_ratio,
  output logic signed [15:0]      vertical_ratio,
  output logic signed [15:0]      look_sin,
  output logic signed [15:0]      look_cos,
  output logic                    is_moving,
  output logic signed [15:0]      pitch_ratio
);
  import vlaf_pkg::*;

  localparam int N = CORDIC_STAGES;

  // request state through the vectoring section
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic [31:0]        z;
    logic               vzero;
    logic [15:0]        yaw;
    logic [15:0]        vr;
    logic [15:0]        pr;
  } vec_t;

  // request state through the rotation section
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] a;
    logic               flip;
    logic               moving;
    logic [32:0]        hsp;
    logic [56:0]        sprod;
    logic [15:0]        sp;
    logic [15:0]        vr;
    logic [15:0]        pr;
  } rot_t;

  // configuration registers
  logic [15:0] moving_threshold;
  logic [23:0] speed_reciprocal;
  logic [23:0] pitch_reciprocal;

  always_ff @(posedge clk) begin
    if (rst) begin
      moving_threshold <= MOVING_THRESHOLD_RESET;
      speed_reciprocal <= SPEED_RECIPROCAL_RESET;
      pitch_reciprocal <= PITCH_RECIPROCAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVING_THRESHOLD: moving_threshold <= cfg_data[15:0];
        REG_SPEED_RECIPROCAL: speed_reciprocal <= cfg_data;
        REG_PITCH_RECIPROCAL: pitch_reciprocal <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result sits untaken
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // ---------------------------------------------------------------------
  // entry stage: fold into the right half plane, start the ratio products
  // ---------------------------------------------------------------------
  vec_t               vec   [N+1];
  logic               vval  [N+1];
  logic signed [39:0] vprod;
  logic signed [39:0] pprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vval[0] <= 1'b0;
    end else if (advance) begin
      vval[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (vel_x < 0) begin
        vec[0].x <= -({{18{vel_x[15]}}, vel_x} <<< 16);
        vec[0].y <= -({{18{vel_y[15]}}, vel_y} <<< 16);
        vec[0].z <= 32'h8000_0000;
      end else begin
        vec[0].x <= {{18{vel_x[15]}}, vel_x} <<< 16;
        vec[0].y <= {{18{vel_y[15]}}, vel_y} <<< 16;
        vec[0].z <= 32'd0;
      end
      vec[0].vzero <= (vel_x == 16'sd0) && (vel_y == 16'sd0);
      vec[0].yaw   <= yaw_angle;
      vec[0].vr    <= 16'd0;
      vec[0].pr    <= 16'd0;
      vprod <= vel_z * $signed({1'b0, speed_reciprocal});
      pprod <= pitch_angle * $signed({1'b0, pitch_reciprocal});
    end
  end

  // ---------------------------------------------------------------------
  // vectoring section: one micro-rotation per stage toward the x axis
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_vec
    vec_t vnext;
    always_comb begin
      vnext = vec[i];
      if (vec[i].y < 0) begin
        vnext.x = vec[i].x - (vec[i].y >>> i);
        vnext.y = vec[i].y + (vec[i].x >>> i);
        vnext.z = vec[i].z - ATAN_TAB[i];
      end else begin
        vnext.x = vec[i].x + (vec[i].y >>> i);
        vnext.y = vec[i].y - (vec[i].x >>> i);
        vnext.z = vec[i].z + ATAN_TAB[i];
      end
    end

    if (i == 0) begin : g_ratio
      // round half away from zero, then saturate, for both ratio products
      logic [39:0] vmag;
      logic [39:0] pmag;
      logic [28:0] vrnd;
      logic [21:0] prnd;
      logic [15:0] vr_sat;
      logic [15:0] pr_sat;
      vec_t        vfull;
      always_comb begin
        vmag = vprod[39] ? 40'(-vprod) : 40'(vprod);
        pmag = pprod[39] ? 40'(-pprod) : 40'(pprod);
        vrnd = 29'((vmag + 40'd2048) >> 12);
        prnd = 22'((pmag + 40'd262144) >> 19);
        if (vprod[39]) begin
          vr_sat = (vrnd > 29'd32768) ? 16'h8000 : 16'(-vrnd);
        end else begin
          vr_sat = (vrnd > 29'd32767) ? 16'h7fff : vrnd[15:0];
        end
        if (pprod[39]) begin
          pr_sat = (prnd > 22'd32768) ? 16'h8000 : 16'(-prnd);
        end else begin
          pr_sat = (prnd > 22'd32767) ? 16'h7fff : prnd[15:0];
        end
        // ratios join the request as it leaves the first stage
        vfull    = vnext;
        vfull.vr = vr_sat;
        vfull.pr = pr_sat;
      end
      always_ff @(posedge clk) begin
        if (advance) begin
          vec[i+1] <= vfull;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (advance) begin
          vec[i+1] <= vnext;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vval[i+1] <= 1'b0;
      end else if (advance) begin
        vval[i+1] <= vval[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // gain stage: magnitude times 1/gain, heading
  // ---------------------------------------------------------------------
  logic        mval;
  logic [62:0] mprod;
  logic [31:0] mheading;
  logic [15:0] myaw;
  logic [15:0] mvr;
  logic [15:0] mpr;
  logic [32:0] xpos;

  assign xpos = vec[N].x[33] ? 33'd0 : vec[N].x[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mval <= 1'b0;
    end else if (advance) begin
      mval <= vval[N];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mprod    <= xpos * INV_GAIN_Q30;
      mheading <= vec[N].vzero ? 32'd0 : vec[N].z;
      myaw     <= vec[N].yaw;
      mvr      <= vec[N].vr;
      mpr      <= vec[N].pr;
    end
  end

  // ---------------------------------------------------------------------
  // setup stage: round speed, moving flag, relative angle folded to +-90
  // ---------------------------------------------------------------------
  rot_t               rot  [N+1];
  logic               rval [N+1];
  logic [63:0]        hsum;
  logic [32:0]        hsp;
  logic [31:0]        diff;
  logic signed [33:0] sd;
  logic signed [33:0] sd_fold;
  logic               flip;

  always_comb begin
    hsum = {1'b0, mprod} + 64'd536870912;
    hsp  = hsum[62:30];
    diff = {myaw, 16'd0} - mheading;
    sd   = {{2{diff[31]}}, diff};
    if (sd > 34'sd1073741824) begin
      sd_fold = sd - 34'sd2147483648;
      flip    = 1'b1;
    end else if (sd < -34'sd1073741824) begin
      sd_fold = sd + 34'sd2147483648;
      flip    = 1'b1;
    end else begin
      sd_fold = sd;
      flip    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rval[0] <= 1'b0;
    end else if (advance) begin
      rval[0] <= mval;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rot[0].x      <= 34'($signed({1'b0, INV_GAIN_Q30}));
      rot[0].y      <= 34'sd0;
      rot[0].a      <= sd_fold;
      rot[0].flip   <= flip;
      rot[0].moving <= hsp >= {1'b0, moving_threshold, 16'd0};
      rot[0].hsp    <= hsp;
      rot[0].sprod  <= 57'd0;
      rot[0].sp     <= 16'd0;
      rot[0].vr     <= mvr;
      rot[0].pr     <= mpr;
    end
  end

  // ---------------------------------------------------------------------
  // rotation section: sine and cosine of the relative angle; the speed
  // ratio product and its rounding ride along in the first two stages
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_rot
    rot_t rnext;
    logic [57:0] ssum;
    always_comb begin
      rnext = rot[i];
      ssum  = {1'b0, rot[i].sprod} + 58'd134217728;
      if (rot[i].a >= 0) begin
        rnext.x = rot[i].x - (rot[i].y >>> i);
        rnext.y = rot[i].y + (rot[i].x >>> i);
        rnext.a = rot[i].a - $signed({2'b00, ATAN_TAB[i]});
      end else begin
        rnext.x = rot[i].x + (rot[i].y >>> i);
        rnext.y = rot[i].y - (rot[i].x >>> i);
        rnext.a = rot[i].a + $signed({2'b00, ATAN_TAB[i]});
      end
      if (i == 0) begin
        rnext.sprod = rot[i].hsp * speed_reciprocal;
      end
      if (i == 1) begin
        rnext.sp = (ssum[57:28] > 30'd65535) ? 16'hffff : ssum[43:28];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rot[i+1] <= rnext;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rval[i+1] <= 1'b0;
      end else if (advance) begin
        rval[i+1] <= rval[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // output stage: round to Q1.15, clamp, undo the fold, gate on moving
  // ---------------------------------------------------------------------
  logic signed [33:0] cos_r;
  logic signed [33:0] sin_r;
  logic signed [15:0] cos_c;
  logic signed [15:0] sin_c;
  logic signed [15:0] cos_o;
  logic signed [15:0] sin_o;

  always_comb begin
    cos_r = (rot[N].x + 34'sd16384) >>> 15;
    sin_r = (rot[N].y + 34'sd16384) >>> 15;
    if (cos_r > 34'sd32767) begin
      cos_c = 16'sd32767;
    end else if (cos_r < -34'sd32767) begin
      cos_c = -16'sd32767;
    end else begin
      cos_c = cos_r[15:0];
    end
    if (sin_r > 34'sd32767) begin
      sin_c = 16'sd32767;
    end else if (sin_r < -34'sd32767) begin
      sin_c = -16'sd32767;
    end else begin
      sin_c = sin_r[15:0];
    end
    if (!rot[N].moving) begin
      cos_o = 16'sd0;
      sin_o = 16'sd0;
    end else if (rot[N].flip) begin
      cos_o = -cos_c;
      sin_o = -sin_c;
    end else begin
      cos_o = cos_c;
      sin_o = sin_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= rval[N];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      speed_ratio    <= rot[N].sp;
      vertical_ratio <= rot[N].vr;
      pitch_ratio    <= rot[N].pr;
      look_cos       <= cos_o;
      look_sin       <= sin_o;
      is_moving      <= rot[N].moving;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // a stationary request never carries a look direction
  a_still_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_moving) |-> (look_sin == 16'sd0 && look_cos == 16'sd0))
    else $error("look fields nonzero while not moving");

  // clamped sine and cosine never reach the most negative code
  a_look_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (look_sin != 16'sh8000 && look_cos != 16'sh8000))
    else $error("look field out of range");

  // no request is taken while a finished result is held back
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken during output stall");

  // a held result stays put until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(speed_ratio) && $stable(look_sin)))
    else $error("held result changed");

endmodule

`default_nettype wire
